// ----- src/stbs_pkg.sv -----
// Package: shared types, constants and defaults for the sorted table search unit.
`default_nettype none
package stbs_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_ENTRY_WIDTH = 32;
    localparam int CFG_W           = 11;
    localparam int IDX_W           = 10;
    localparam int KEY_W           = 32;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1;
    localparam logic             REQ_WRITE     = 1'b0;
    localparam logic             REQ_SEARCH    = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_index;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr;
        logic start;
        logic issue;
        logic step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic finish;
    } t_dp_stat;

endpackage
`default_nettype wire

// ----- src/stbs_datapath.sv -----
// Datapath: table memory, config register, search bounds, compare and result registers.
`default_nettype none
module stbs_datapath
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire t_in_word         i_in_word,
    input  wire t_dp_cmd          i_cmd,
    output      t_dp_stat         o_stat,
    output      t_out_word        o_out_word
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (ENTRY_WIDTH > KEY_W) ? ENTRY_WIDTH : KEY_W;

    logic signed [ENTRY_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic signed [ENTRY_WIDTH-1:0] r_rd;
    logic [CFG_W-1:0]              r_entries;
    logic signed [KEY_W-1:0]       r_key;
    logic [CW-1:0]                 r_lo;
    logic [CW-1:0]                 r_hi;
    logic [CW-1:0]                 r_mid;
    t_out_word                     r_res;
    t_out_word                     r_out;

    logic [CW-1:0]                 count;
    logic [CW:0]                   sum_cur;
    logic [CW-1:0]                 mid_cur;
    logic [CW-1:0]                 n_lo;
    logic [CW-1:0]                 n_hi;
    logic [CW:0]                   sum_next;
    logic [CW-1:0]                 n_mid;
    logic signed [CMP_W-1:0]       key_ext;
    logic signed [CMP_W-1:0]       ent_ext;
    logic                          lt;
    logic                          gt;
    logic                          miss;
    logic                          wr_ok;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;

    always_comb begin
        if (32'(r_entries) > 32'(TABLE_DEPTH)) begin
            count = CW'(TABLE_DEPTH);
        end else begin
            count = CW'(r_entries);
        end
        sum_cur  = {1'b0, r_lo} + {1'b0, r_hi};
        mid_cur  = sum_cur[CW:1];
        key_ext  = CMP_W'(r_key);
        ent_ext  = CMP_W'(r_rd);
        lt       = key_ext < ent_ext;
        gt       = key_ext > ent_ext;
        n_lo     = r_lo;
        n_hi     = r_hi;
        miss     = 1'b0;
        if (lt) begin
            if (r_mid == '0) begin
                miss = 1'b1;
            end else begin
                n_hi = r_mid - CW'(1);
            end
        end else if (gt) begin
            n_lo = r_mid + CW'(1);
        end
        if (n_lo > n_hi) begin
            miss = 1'b1;
        end
        sum_next = {1'b0, n_lo} + {1'b0, n_hi};
        n_mid    = sum_next[CW:1];
        o_stat.empty  = (count == '0);
        o_stat.finish = (!lt && !gt) || miss;
        wr_ok    = 32'(i_in_word.entry_index) < 32'(TABLE_DEPTH);
        rd_en    = i_cmd.issue || (i_cmd.step && !o_stat.finish);
        rd_addr  = i_cmd.issue ? mid_cur[AW-1:0] : n_mid[AW-1:0];
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            r_mem[AW'(i_in_word.entry_index)] <= ENTRY_WIDTH'(i_in_word.value);
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RESET;
        end else if (i_cfg_valid) begin
            r_entries <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= i_in_word.value;
            r_lo  <= '0;
            r_hi  <= count - CW'(1);
            r_res <= '0;
        end
        if (i_cmd.issue) begin
            r_mid <= mid_cur;
        end
        if (i_cmd.step) begin
            if (!lt && !gt) begin
                r_res.found       <= 1'b1;
                r_res.found_index <= IDX_W'(r_mid);
            end else if (!miss) begin
                r_lo  <= n_lo;
                r_hi  <= n_hi;
                r_mid <= n_mid;
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_word = r_out;

endmodule
`default_nettype wire

// ----- src/stbs_ctrl.sv -----
// Controller: search sequencing state machine and handshake control.
`default_nettype none
module stbs_ctrl
    import stbs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_req_type,
    output      logic     o_in_stall,
    output      logic     o_out_valid,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output      t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = (r_state != S_IDLE);
        accept      = i_in_valid && (r_state == S_IDLE);
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = i_stat.empty ? S_DONE : S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.step = 1'b1;
                if (i_stat.finish) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- src/sorted_table_binary_search_unit.sv -----
// Top level: sorted table binary search unit.
// Write word: written to the table when accepted, next word may follow in the next cycle.
// Search word: states ISSUE, then PROBE for P probes (both skipped for an empty table), then DONE;
//   P = probes, at most ceil(log2(count+1)) (11 at 1024 entries), one per cycle; next word taken in IDLE.
// A stalled result holds the next finished search until the result word is taken.
// Synchronous active-low reset clears control, sets entries_in_use to 1; table undefined.
`default_nettype none
module sorted_table_binary_search_unit
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output      logic             o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output      logic             o_in_stall,
    input  wire t_in_word         i_in_word,
    output      logic             o_out_valid,
    input  wire logic             i_out_stall,
    output      t_out_word        o_out_word
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_word.req_type),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire

// ----- src/stbs_checker.sv -----
// Checker: port-level assertions for the search unit, bound to the top level.
`default_nettype none
module stbs_checker
    import stbs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire t_in_word         i_in_word,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire t_out_word        o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word dropped or changed");

    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.found || (o_out_word.found_index == '0)))
        else $error("miss reported with nonzero index");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.req_type == REQ_SEARCH) |=> o_in_stall)
        else $error("new word taken while a search runs");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.req_type == REQ_WRITE) |=> !o_in_stall)
        else $error("write word did not complete in one cycle");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (.*);
`default_nettype wire

// ----- tb/tb_sorted_table_binary_search_unit.sv -----
// Testbench for sorted_table_binary_search_unit: random and directed table writes and searches,
// checked against a bisection predictor.
`timescale 1ns / 100ps
module tb_sorted_table_binary_search_unit;
    import stbs_pkg::*;

    localparam int DEPTH       = DEF_TABLE_DEPTH;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 20;
    localparam int HOLD_LEN    = 300;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    t_in_word         in_word   = '0;
    logic             out_stall = 1'b0;
    logic             quiet     = 1'b0;
    logic             hold_go   = 1'b0;
    wire              o_cfg_ready;
    wire              o_in_stall;
    wire              o_out_valid;
    t_out_word        o_out_word;

    // predictor state
    logic signed [KEY_W-1:0] table_model [DEPTH];
    logic [CFG_W-1:0]        entries_model = ENTRIES_RESET;
    t_out_word               lookup_answers [$];

    // stimulus side
    t_in_word                queued_requests [$];
    logic signed [KEY_W-1:0] shadow [DEPTH];
    logic signed [KEY_W-1:0] ladder [DEPTH];

    int        fail_count  = 0;
    int        cycle_count = 0;
    int        send_gap    = 0;
    int        stall_left  = 0;
    int        hold_left   = 0;
    bit        hold_used   = 1'b0;
    bit        offering;
    t_out_word want;

    sorted_table_binary_search_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic t_out_word bisect_table(input logic signed [KEY_W-1:0] key);
        t_out_word r;
        int        span;
        int        lo;
        int        hi;
        int        mid;
        bit        done;
        r    = '0;
        span = (entries_model > DEPTH) ? DEPTH : int'(entries_model);
        lo   = 0;
        hi   = span - 1;
        done = 1'b0;
        while (!done && lo <= hi) begin
            mid = (lo + hi) / 2;
            if (key < table_model[mid]) begin
                if (mid == 0)
                    done = 1'b1;
                else
                    hi = mid - 1;
            end else if (key > table_model[mid]) begin
                lo = mid + 1;
            end else begin
                r.found       = 1'b1;
                r.found_index = mid[IDX_W-1:0];
                done          = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void apply_word(input t_in_word w);
        if (w.req_type == REQ_WRITE)
            table_model[w.entry_index] = w.value;
        else
            lookup_answers.push_back(bisect_table(w.value));
    endfunction

    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            offering = in_valid;
            if (in_valid && !o_in_stall) begin
                apply_word(in_word);
                offering = 1'b0;
                send_gap = pick_gap(quiet);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                end else if (queued_requests.size() > 0) begin
                    in_word <= queued_requests.pop_front();
                    offering = 1'b1;
                end
                in_valid <= offering;
            end
        end
    end

    // result stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_LEN;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end else begin
            stall_left = pick_gap(quiet);
            out_stall <= (stall_left != 0);
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (lookup_answers.size() == 0) begin
                $error("result word with nothing pending: found=%0d found_index=%0d",
                       o_out_word.found, o_out_word.found_index);
                fail_count = fail_count + 1;
            end else begin
                want = lookup_answers.pop_front();
                if (o_out_word.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_out_word.found);
                    fail_count = fail_count + 1;
                end
                if (o_out_word.found_index !== want.found_index) begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, o_out_word.found_index);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    task automatic queue_write(input int idx, input logic signed [KEY_W-1:0] val);
        t_in_word w;
        w.req_type    = REQ_WRITE;
        w.entry_index = idx[IDX_W-1:0];
        w.value       = val;
        shadow[idx]   = val;
        queued_requests.push_back(w);
    endtask

    task automatic queue_search(input logic signed [KEY_W-1:0] key);
        t_in_word w;
        w.req_type    = REQ_SEARCH;
        w.entry_index = IDX_W'($urandom);
        w.value       = key;
        queued_requests.push_back(w);
    endtask

    // sampled at the falling edge, where driver and monitor updates have settled
    task automatic wait_drained();
        while (queued_requests.size() != 0 || in_valid || lookup_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_entries(input logic [CFG_W-1:0] n);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge clk); while (!o_cfg_ready);
        entries_model = n;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_item();
        int              roll;
        int              span;
        int              idx;
        longint          lo;
        longint          hi;
        logic signed [KEY_W-1:0] key;
        roll = $urandom_range(0, 99);
        span = (entries_model > DEPTH) ? DEPTH : int'(entries_model);
        idx  = $urandom_range(0, DEPTH - 1);
        if (roll < 5) begin
            queue_write(idx, $urandom);
        end else if (roll < 20) begin
            // keep ascending order: value between the neighbors
            lo = (idx == 0) ? longint'(KEY_MIN) : longint'(shadow[idx - 1]);
            hi = (idx == DEPTH - 1) ? longint'(KEY_MAX) : longint'(shadow[idx + 1]);
            if (lo >= hi)
                queue_write(idx, lo[KEY_W-1:0]);
            else
                queue_write(idx, KEY_W'(lo + longint'({$urandom, $urandom} % (hi - lo + 1))));
        end else begin
            if (roll < 60 && span > 0)
                key = shadow[$urandom_range(0, span - 1)];
            else if (roll < 75 && span > 0)
                key = shadow[$urandom_range(0, span - 1)] + ($urandom_range(0, 1) ? 1 : -1);
            else
                key = $urandom;
            queue_search(key);
        end
    endtask

    logic [CFG_W-1:0] phase_entries [7];

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // ascending fill, ends kept one step inside the key range
        for (int i = 0; i < DEPTH; i++)
            ladder[i] = KEY_W'(longint'(KEY_MIN) + longint'(i) * 4194304
                               + longint'($urandom_range(0, 4194303)));
        ladder[0]         = KEY_MIN + 1;
        ladder[DEPTH - 1] = KEY_MAX - 1;
        for (int i = 0; i < DEPTH; i++)
            queue_write(i, ladder[i]);

        // one entry in use after reset
        queue_search(ladder[0]);
        queue_search(KEY_MIN);
        queue_search(KEY_MAX);

        set_entries(11'd1024);
        queue_search(ladder[0]);
        queue_search(ladder[DEPTH - 1]);
        queue_search(ladder[511]);
        queue_search(ladder[512]);
        queue_search(ladder[700] + 1);
        queue_search(KEY_MIN);
        queue_search(KEY_MAX);
        queue_search(-32'sd1);
        queue_search(32'sd0);
        queue_write(0, KEY_MIN);
        queue_write(DEPTH - 1, KEY_MAX);
        queue_search(KEY_MIN);
        queue_search(KEY_MAX);
        // out-of-order entry, then repaired
        queue_write(300, ladder[900]);
        queue_search(ladder[300]);
        queue_search(ladder[900]);
        queue_write(300, ladder[300]);

        set_entries(11'd0);
        queue_search(ladder[5]);
        set_entries(11'd2047);
        queue_search(KEY_MAX);
        queue_search(ladder[100]);
        set_entries(11'd2);
        queue_search(shadow[1]);
        queue_search(shadow[2]);

        phase_entries[0] = 11'd1024;
        phase_entries[1] = 11'd1;
        phase_entries[2] = 11'($urandom_range(3, 1023));
        phase_entries[3] = 11'd2047;
        phase_entries[4] = 11'd2;
        phase_entries[5] = 11'($urandom_range(1, 1024));
        phase_entries[6] = 11'd1024;
        for (int ph = 0; ph < 7; ph++) begin
            set_entries(phase_entries[ph]);
            quiet <= (ph == 2 || ph == 5);
            for (int k = 0; k < 100; k++)
                queue_random_item();
            if (ph == 3)
                hold_go <= 1'b1;
        end

        wait_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
